@@ src/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded double-ended queue: command and
// result words, opcodes, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned LenW  = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_UPDATE     = 3'd4,
    OP_DUMP       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    op_e                     opcode;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] new_value;
  } cmd_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] element;
    logic                    element_valid;
    logic [LenW-1:0]         length;
    logic                    last;
  } res_t;

endpackage

@@ src/bdq_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write the word, register the read word; a read of the address being
  // written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bounded_deque_with_update.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_update
// Bounded double-ended queue of signed 32-bit words in a ring RAM, with
// push/pop at both ends, in-place update of matching entries and dump.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Push, pop and
// any update or dump of an empty queue keep busy low, and the single result
// word appears on res_o with res_valid_o high in the next cycle. Update and
// dump of N entries hold busy high while the sequencer walks the ring RAM
// through its one registered read port, one entry per cycle; dump results
// stream out one per entry without gaps and update gives one result at the
// end. A result is on the ports for exactly one cycle and the receiver cannot
// stall it, so it must capture every strobed word. Pushes into a full queue
// are dropped and reported with status full.
// ----------------------------------------------------------------------------
module bounded_deque_with_update #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bdq_pkg::cmd_t    cmd_i,
  output logic             res_valid_o,
  output bdq_pkg::res_t    res_o
);

  import bdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // ring position of logical entry pos, wrapped by one compare and subtract
  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] front,
                                              input logic [IdxW-1:0] pos);
    logic [IdxW:0] sum;
    begin
      sum = {1'b0, front} + {1'b0, pos};
      if (sum >= (IdxW+1)'(DEPTH)) begin
        sum = sum - (IdxW+1)'(DEPTH);
      end
      return sum[IdxW-1:0];
    end
  endfunction

  // length reported modulo 2**LenW
  function automatic logic [LenW-1:0] len_of(input logic [CntW-1:0] cnt);
    logic [CntW+LenW-1:0] ext;
    begin
      ext = (CntW+LenW)'(cnt);
      return ext[LenW-1:0];
    end
  endfunction

  state_e          state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_pos_q, rd_pos_d;
  logic            chk_vld_q, chk_vld_d;
  logic            chk_last_q, chk_last_d;
  logic [IdxW-1:0] chk_slot_q, chk_slot_d;
  logic            hit_q, hit_d;
  op_e             op_q, op_d;
  word_t           key_q, key_d;
  word_t           val_q, val_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;

  logic            accept;
  logic            full;
  logic            empty;
  logic [IdxW-1:0] front_dec;
  logic [IdxW-1:0] front_inc;
  logic [IdxW-1:0] rd_slot;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  word_t           mem_wdata;
  word_t           mem_rdata;
  logic            match;

  assign accept    = start && !busy;
  assign busy      = (state_q == S_WALK);
  assign full      = (cnt_q == CntW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - IdxW'(1);
  assign front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + IdxW'(1);
  assign rd_slot   = slot_of(front_q, rd_pos_q[IdxW-1:0]);
  assign match     = (mem_rdata == key_q);

  bdq_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_slot),
    .rdata_o (mem_rdata)
  );

  // sequencer: single-cycle commands in idle, ring walk for update and dump
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    rd_pos_d    = rd_pos_q;
    chk_vld_d   = 1'b0;
    chk_last_d  = chk_last_q;
    chk_slot_d  = chk_slot_q;
    hit_d       = hit_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = chk_slot_q;
    mem_wdata   = val_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d               = cmd_i.opcode;
          key_d              = word_t'(cmd_i.key);
          val_d              = word_t'(cmd_i.new_value);
          res_valid_d        = 1'b1;
          res_d.status       = STAT_OK;
          res_d.element      = '0;
          res_d.element_valid = 1'b0;
          res_d.last         = 1'b1;
          case (cmd_i.opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                front_d   = front_dec;
                cnt_d     = cnt_q + CntW'(1);
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                mem_wdata = word_t'(cmd_i.new_value);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                cnt_d     = cnt_q + CntW'(1);
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_q, cnt_q[IdxW-1:0]);
                mem_wdata = word_t'(cmd_i.new_value);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                front_d = front_inc;
                cnt_d   = cnt_q - CntW'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                cnt_d = cnt_q - CntW'(1);
              end
            end
            OP_UPDATE: begin
              if (empty) begin
                res_d.status = STAT_NOTFOUND;
              end else begin
                res_valid_d = 1'b0;
                state_d     = S_WALK;
                rd_pos_d    = '0;
                hit_d       = 1'b0;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                res_valid_d = 1'b0;
                state_d     = S_WALK;
                rd_pos_d    = '0;
              end
            end
            default: begin
              // unused opcodes leave the queue alone
              res_d.status = STAT_OK;
            end
          endcase
          res_d.length = len_of(cnt_d);
        end
      end

      S_WALK: begin
        // issue the next read while entries remain
        if (rd_pos_q < cnt_q) begin
          chk_vld_d  = 1'b1;
          chk_slot_d = rd_slot;
          chk_last_d = (rd_pos_q == cnt_q - CntW'(1));
          rd_pos_d   = rd_pos_q + CntW'(1);
        end
        // check the word read last cycle
        if (chk_vld_q) begin
          res_d.length = len_of(cnt_q);
          if (op_q == OP_UPDATE) begin
            if (match) begin
              mem_we = 1'b1;
              hit_d  = 1'b1;
            end
            if (chk_last_q) begin
              res_valid_d         = 1'b1;
              res_d.status        = (hit_q || match) ? STAT_OK : STAT_NOTFOUND;
              res_d.element       = '0;
              res_d.element_valid = 1'b0;
              res_d.last          = 1'b1;
              state_d             = S_IDLE;
            end
          end else begin
            res_valid_d         = 1'b1;
            res_d.status        = STAT_OK;
            res_d.element       = mem_rdata;
            res_d.element_valid = 1'b1;
            res_d.last          = chk_last_q;
            if (chk_last_q) begin
              state_d = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      rd_pos_q    <= '0;
      chk_vld_q   <= 1'b0;
      chk_last_q  <= 1'b0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      rd_pos_q    <= rd_pos_d;
      chk_vld_q   <= chk_vld_d;
      chk_last_q  <= chk_last_d;
      hit_q       <= hit_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_slot_q <= chk_slot_d;
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // the walk only runs over a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (cnt_q != '0))
    else $error("walk running on an empty queue");

  // the fill count never passes the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  // RAM writes come only from an accepted push or an update walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (accept || (state_q == S_WALK && op_q == OP_UPDATE)))
    else $error("unexpected RAM write");

  // a dumped word always carries status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.element_valid) |-> (res_o.status == STAT_OK))
    else $error("dumped word with bad status");

  // dump words stream without gaps until the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |=> res_valid_o)
    else $error("gap inside a dump stream");

endmodule
